/* rtl/core/spitcs_pkg.sv */
// Shared types, protocol constants and the CRC-8 helper for the SPI touch
// command sequencer. Depends on nothing; used by spi_touch_command_sequencer_top.
`default_nettype none

package spitcs_pkg;

    // Protocol bytes.
    localparam logic [7:0] ACK_CODE  = 8'h55;
    localparam logic [7:0] FILL_BYTE = 8'h00;
    localparam logic [7:0] CRC_POLY  = 8'h8C;

    // Request operations.
    localparam logic [2:0] OP_START_CTRL = 3'd0;
    localparam logic [2:0] OP_START_RPT  = 3'd1;
    localparam logic [2:0] OP_START_SET  = 3'd2;
    localparam logic [2:0] OP_START_WR   = 3'd3;
    localparam logic [2:0] OP_EXCHANGE   = 3'd4;

    // Transaction kinds, equal to the low bits of the start operation.
    localparam logic [1:0] KIND_CTRL = 2'd0;
    localparam logic [1:0] KIND_RPT  = 2'd1;
    localparam logic [1:0] KIND_SET  = 2'd2;
    localparam logic [1:0] KIND_WR   = 2'd3;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_CMD_WAIT   = 4'd1;
    localparam logic [3:0] PH_CTRL_CRC   = 4'd2;
    localparam logic [3:0] PH_RPT_CMDCRC = 4'd3;
    localparam logic [3:0] PH_RPT_DATA   = 4'd4;
    localparam logic [3:0] PH_RPT_CRC    = 4'd5;
    localparam logic [3:0] PH_SET_DATA   = 4'd6;
    localparam logic [3:0] PH_SET_CRC    = 4'd7;
    localparam logic [3:0] PH_WR_DATA    = 4'd8;
    localparam logic [3:0] PH_WR_CRC     = 4'd9;

    // One result item.
    typedef struct packed {
        logic       ok;
        logic       done_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       send_byte;
        logic [7:0] mosi_byte;
    } t_result;

    // Reflected CRC-8 update over one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       lsb;
        c = crc_in;
        d = data_in;
        for (int k = 0; k < 8; k++) begin
            lsb = c[0] ^ d[0];
            d   = d >> 1;
            c   = c >> 1;
            if (lsb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/spi_touch_command_sequencer_top.sv */
// Top level of the SPI touch command sequencer: transaction state, CRC-8
// checking and a two-entry result buffer. Depends on spitcs_pkg.
`default_nettype none

// The block takes one request per clock cycle while o_s_tready is high and
// returns exactly one result for each. With the output register free, the
// result is registered there; behind a waiting result it lands in the skid
// register and follows once the waiting one has gone. Each request is either a
// start of a transaction or the report of one finished SPI byte exchange; the
// result tells the SPI engine which byte to shift next, hands over report
// bytes and flags the end of the transaction with its CRC status. All the
// work for a request is done in one pass of logic whose longest path is two
// chained CRC-8 byte updates. Results sit in an output register backed by a
// skid register, so a request is still taken while one finished result waits;
// only when both are full is o_s_tready low. The CRC enable register may be
// written through the configuration channel at any cycle (o_cfg_ready is
// always high) and should be changed only while the block is idle.
module spi_touch_command_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: bit 0 is crc_enable.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // Request side.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // cmd[7:0], payload[15:8], count[23:16], miso[31:24]
    input  wire logic [2:0]  i_s_tuser,  // operation[2:0]
    // Result side.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,  // mosi_byte[7:0], read_byte[15:8]
    output logic [3:0]       o_m_tuser   // send_byte[0], read_valid[1], done_res[2], ok[3]
);

    // Handshakes.
    logic s_acc;
    logic m_acc;

    // Request fields.
    logic [2:0] op;
    logic [7:0] in_cmd;
    logic [7:0] in_pay;
    logic [7:0] in_cnt;
    logic [7:0] in_miso;

    // Transaction state.
    logic       r_crc_en;
    logic [3:0] r_phase, n_phase;
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_left, n_left;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_set, n_set;

    // Result buffer.
    logic                 r_out_valid;
    logic                 r_skid_valid;
    spitcs_pkg::t_result  r_out;
    spitcs_pkg::t_result  r_skid;
    spitcs_pkg::t_result  n_res;

    // Shared CRC terms.
    logic [7:0] crc_cmd;
    logic [7:0] crc_acc_pay;
    logic [7:0] crc_cmd_pay;
    logic [7:0] crc_cmd_set;
    logic [7:0] crc_acc_miso;
    logic [7:0] left_dec;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    assign op      = i_s_tuser;
    assign in_cmd  = i_s_tdata[7:0];
    assign in_pay  = i_s_tdata[15:8];
    assign in_cnt  = i_s_tdata[23:16];
    assign in_miso = i_s_tdata[31:24];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_skid_valid;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out.read_byte, r_out.mosi_byte};
    assign o_m_tuser   = {r_out.ok, r_out.done_res, r_out.read_valid, r_out.send_byte};

    // CRC updates used by the phase logic.
    assign crc_cmd      = spitcs_pkg::crc8_byte(8'h00, r_cmd);
    assign crc_acc_pay  = spitcs_pkg::crc8_byte(r_crc, in_pay);
    assign crc_cmd_pay  = spitcs_pkg::crc8_byte(crc_cmd, in_pay);
    assign crc_cmd_set  = spitcs_pkg::crc8_byte(crc_cmd, r_set);
    assign crc_acc_miso = spitcs_pkg::crc8_byte(r_crc, in_miso);
    assign left_dec     = r_left - 8'd1;

    // Next state and result for the request on the input.
    always_comb begin
        logic [7:0] rpt_left;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_cmd   = r_cmd;
        n_left  = r_left;
        n_crc   = r_crc;
        n_set   = r_set;
        n_res   = '0;
        rpt_left = (r_left != 8'd0) ? left_dec : 8'd0;

        if (op inside {spitcs_pkg::OP_START_CTRL, spitcs_pkg::OP_START_RPT,
                       spitcs_pkg::OP_START_SET, spitcs_pkg::OP_START_WR}) begin
            // A start opens a transaction only while idle.
            if (r_phase == spitcs_pkg::PH_IDLE) begin
                n_kind  = op[1:0];
                n_cmd   = in_cmd;
                n_left  = in_cnt;
                n_set   = in_pay;
                n_crc   = 8'h00;
                n_phase = spitcs_pkg::PH_CMD_WAIT;
                n_res.mosi_byte = in_cmd;
                n_res.send_byte = 1'b1;
            end
        end else if (op == spitcs_pkg::OP_EXCHANGE) begin
            case (r_phase)
                spitcs_pkg::PH_IDLE: begin
                    n_phase = spitcs_pkg::PH_IDLE;
                end
                spitcs_pkg::PH_CMD_WAIT: begin
                    n_res.send_byte = 1'b1;
                    if (in_miso != spitcs_pkg::ACK_CODE) begin
                        // No acknowledge yet: resend the command.
                        n_res.mosi_byte = r_cmd;
                    end else begin
                        n_crc = crc_cmd;
                        case (r_kind)
                            spitcs_pkg::KIND_CTRL: begin
                                if (r_crc_en) begin
                                    n_res.mosi_byte = crc_cmd;
                                    n_phase = spitcs_pkg::PH_CTRL_CRC;
                                end else begin
                                    n_res = '0;
                                    n_res.done_res = 1'b1;
                                    n_res.ok = 1'b1;
                                    n_phase = spitcs_pkg::PH_IDLE;
                                end
                            end
                            spitcs_pkg::KIND_RPT: begin
                                if (r_crc_en) begin
                                    n_res.mosi_byte = crc_cmd;
                                    n_phase = spitcs_pkg::PH_RPT_CMDCRC;
                                end else if (r_left != 8'd0) begin
                                    n_res.mosi_byte = spitcs_pkg::FILL_BYTE;
                                    n_phase = spitcs_pkg::PH_RPT_DATA;
                                end else begin
                                    n_res = '0;
                                    n_res.done_res = 1'b1;
                                    n_res.ok = 1'b1;
                                    n_phase = spitcs_pkg::PH_IDLE;
                                end
                            end
                            spitcs_pkg::KIND_SET: begin
                                n_res.mosi_byte = r_set;
                                n_phase = spitcs_pkg::PH_SET_DATA;
                            end
                            default: begin
                                // Setup write: first data byte, straight to CRC, or done when CRC is off.
                                if (r_left != 8'd0) begin
                                    n_crc  = crc_cmd_pay;
                                    n_left = left_dec;
                                    n_res.mosi_byte = in_pay;
                                    n_phase = spitcs_pkg::PH_WR_DATA;
                                end else if (r_crc_en) begin
                                    n_res.mosi_byte = crc_cmd;
                                    n_phase = spitcs_pkg::PH_WR_CRC;
                                end else begin
                                    n_res = '0;
                                    n_res.done_res = 1'b1;
                                    n_res.ok = 1'b1;
                                    n_phase = spitcs_pkg::PH_IDLE;
                                end
                            end
                        endcase
                    end
                end
                spitcs_pkg::PH_RPT_CMDCRC: begin
                    // The device echoes the command CRC before sending data.
                    if (in_miso != r_crc) begin
                        n_res.done_res = 1'b1;
                        n_phase = spitcs_pkg::PH_IDLE;
                    end else begin
                        n_crc = 8'h00;
                        n_res.mosi_byte = spitcs_pkg::FILL_BYTE;
                        n_res.send_byte = 1'b1;
                        n_phase = (r_left != 8'd0) ? spitcs_pkg::PH_RPT_DATA
                                                   : spitcs_pkg::PH_RPT_CRC;
                    end
                end
                spitcs_pkg::PH_RPT_DATA: begin
                    // Hand over the report byte and keep clocking fill bytes.
                    n_crc  = crc_acc_miso;
                    n_left = rpt_left;
                    n_res.read_valid = 1'b1;
                    n_res.read_byte  = in_miso;
                    if (rpt_left != 8'd0) begin
                        n_res.mosi_byte = spitcs_pkg::FILL_BYTE;
                        n_res.send_byte = 1'b1;
                        n_phase = spitcs_pkg::PH_RPT_DATA;
                    end else if (r_crc_en) begin
                        n_res.mosi_byte = spitcs_pkg::FILL_BYTE;
                        n_res.send_byte = 1'b1;
                        n_phase = spitcs_pkg::PH_RPT_CRC;
                    end else begin
                        n_res.done_res = 1'b1;
                        n_res.ok = 1'b1;
                        n_phase = spitcs_pkg::PH_IDLE;
                    end
                end
                spitcs_pkg::PH_SET_DATA: begin
                    if (r_crc_en) begin
                        n_crc = crc_cmd_set;
                        n_res.mosi_byte = crc_cmd_set;
                        n_res.send_byte = 1'b1;
                        n_phase = spitcs_pkg::PH_SET_CRC;
                    end else begin
                        n_res.done_res = 1'b1;
                        n_res.ok = 1'b1;
                        n_phase = spitcs_pkg::PH_IDLE;
                    end
                end
                spitcs_pkg::PH_WR_DATA: begin
                    if (r_left != 8'd0) begin
                        n_crc  = crc_acc_pay;
                        n_left = left_dec;
                        n_res.mosi_byte = in_pay;
                        n_res.send_byte = 1'b1;
                    end else if (r_crc_en) begin
                        n_res.mosi_byte = r_crc;
                        n_res.send_byte = 1'b1;
                        n_phase = spitcs_pkg::PH_WR_CRC;
                    end else begin
                        n_res.done_res = 1'b1;
                        n_res.ok = 1'b1;
                        n_phase = spitcs_pkg::PH_IDLE;
                    end
                end
                spitcs_pkg::PH_CTRL_CRC, spitcs_pkg::PH_RPT_CRC,
                spitcs_pkg::PH_SET_CRC, spitcs_pkg::PH_WR_CRC: begin
                    // Final CRC byte from the device.
                    n_res.done_res = 1'b1;
                    n_res.ok = (in_miso == r_crc);
                    n_phase = spitcs_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = spitcs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_en <= i_cfg_data;
        end
    end

    // Transaction state advances on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spitcs_pkg::PH_IDLE;
            r_kind  <= spitcs_pkg::KIND_CTRL;
            r_cmd   <= 8'h00;
            r_left  <= 8'h00;
            r_crc   <= 8'h00;
            r_set   <= 8'h00;
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_cmd   <= n_cmd;
            r_left  <= n_left;
            r_crc   <= n_crc;
            r_set   <= n_set;
        end
    end

    // Result buffer valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_acc || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= s_acc;
            end
        end else if (s_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Result buffer payload.
    always_ff @(posedge i_clk) begin
        if (m_acc || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (s_acc) begin
                r_out <= n_res;
            end
        end else if (s_acc) begin
            r_skid <= n_res;
        end
    end

    // The skid register only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    // A finishing result always returns the sequencer to idle.
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_res.done_res) |=> (r_phase == spitcs_pkg::PH_IDLE))
        else $error("transaction finished but phase is not idle");

    // A start request while busy leaves the transaction untouched.
    a_busy_start_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_s_tuser[2] && (r_phase != spitcs_pkg::PH_IDLE))
        |=> ($stable(r_phase) && $stable(r_cmd) && $stable(r_left)))
        else $error("start request changed a running transaction");

    // Success is only flagged on a finishing result.
    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[3]) |-> o_m_tuser[2])
        else $error("ok flag set without done");

endmodule

`default_nettype wire
